FILE: hw/rtl/ran_pkg.sv
// Package for the rational arithmetic normaliser.
// Holds the sequencer and divider state types, operation codes, register reset values and register addresses.
package ran_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_RAW,
    ST_FLUSH,
    ST_GCD,
    ST_QN,
    ST_QD,
    ST_SHIFT,
    ST_DONE
  } state_e;

  typedef enum logic {
    DIV_IDLE,
    DIV_BUSY
  } div_state_e;

  localparam logic [31:0] REDUCE_RESET = 32'd10000;
  localparam logic [31:0] FLUSH_RESET  = 32'd100000;
  localparam logic        REG_REDUCE   = 1'b0;
  localparam logic        REG_FLUSH    = 1'b1;

endpackage

FILE: hw/rtl/ran_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned.
// Depends on ran_pkg.
module ran_div #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);
  import ran_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  div_state_e   state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [W:0]    trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    done_o  = 1'b0;
    trial   = {rem_q, quot_q[W-1]} - {1'b0, dvs_q};
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          quot_d  = dividend_i;
          rem_d   = '0;
          dvs_d   = divisor_i;
          cnt_d   = CW'(W);
          state_d = DIV_BUSY;
        end
      end
      DIV_BUSY: begin
        if (!trial[W]) begin
          rem_d  = trial[W-1:0];
          quot_d = {quot_q[W-2:0], 1'b1};
        end else begin
          rem_d  = {rem_q[W-2:0], quot_q[W-1]};
          quot_d = {quot_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
    done_o = (state_q == DIV_IDLE);
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

FILE: hw/rtl/rational_arith_normalize.sv
// Rational ALU with gcd reduction: one request at a time, sequenced over a
// shared 32x32 multiplier (three partials per W-bit product) and a shared bit-serial divider.
// Steps in order: products, raw result, flush divide, Euclid steps, the two quotient
// divides and the final shifts. A new request is taken only once the result is
// accepted; tready is low while busy. Reset is async, active low, clears control and
// loads register reset values.
module rational_arith_normalize #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // {b_den, b_num, a_den, a_num, req_type}, req_type at bit 0, 6 pad bits at top
  input  logic [263:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // res_num, res_den, a_less, a_equal, a_greater, zero_divisor from bit 0 up
  output logic [135:0] m_axis_tdata_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ran_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned SW = $clog2(W + 1);

  logic [31:0] reduce_q, flush_q;
  state_e      state_q, state_d;
  logic [2:0]  mc_q, mc_d;
  logic [1:0]  ph_q, ph_d;
  logic [SW-1:0] sc_q, sc_d;
  logic [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic [1:0]   op_q;
  logic [W-1:0] p_q [4];
  logic [W-1:0] n_q, n_d, d_q, d_d, x_q, x_d, y_q, y_d, g_q, g_d;
  logic         zf_q, zf_d, ng_q, ng_d, dg_q, dg_d, fl_q, fl_d;
  logic         lt_q, lt_d, eq_q, eq_d, gt_q, gt_d, ov_q;
  logic [W-1:0] mul_a, mul_b, mul_p;
  logic [63:0]  ea, eb, acc_q, mul_p64, mh_p;
  logic [31:0]  mh_a, mh_b;
  logic         div_start, div_done;
  logic [W-1:0] div_n, div_d, div_q, div_r;
  logic [W-1:0] mn, md, nn, dd, wmax;

  function automatic logic [W-1:0] magf(input logic [W-1:0] v);
    magf = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic posf(input logic [W-1:0] v);
    posf = !v[W-1] && (v != '0);
  endfunction

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FLUSH) ? flush_q : reduce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reduce_q <= REDUCE_RESET;
      flush_q  <= FLUSH_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr == {REG_REDUCE, 2'b00}) reduce_q <= pwdata;
      else if (paddr == {REG_FLUSH, 2'b00}) flush_q <= pwdata;
    end
  end

  ran_div #(.W(W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_n), .divisor_i(div_d),
    .done_o(div_done), .quot_o(div_q), .rem_o(div_r)
  );

  always_comb begin
    mul_a = an_q; mul_b = bd_q;
    case (mc_q)
      3'd1: begin mul_a = bn_q; mul_b = ad_q; end
      3'd2: begin mul_a = an_q; mul_b = bn_q; end
      3'd3: begin mul_a = ad_q; mul_b = bd_q; end
      3'd4: begin mul_a = ad_q; mul_b = bn_q; end
      default: ;
    endcase
  end

  // low 64 bits of the product: lo*lo, then the two cross terms shifted up
  assign ea = 64'(mul_a);
  assign eb = 64'(mul_b);
  always_comb begin
    case (ph_q)
      2'd0: begin mh_a = ea[31:0]; mh_b = eb[31:0]; end
      2'd1: begin mh_a = ea[31:0]; mh_b = eb[63:32]; end
      default: begin mh_a = ea[63:32]; mh_b = eb[31:0]; end
    endcase
  end
  assign mh_p    = mh_a * mh_b;
  assign mul_p64 = (ph_q == 2'd0) ? mh_p : acc_q + {mh_p[31:0], 32'd0};
  assign mul_p   = mul_p64[W-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid_i) begin
      op_q <= s_axis_tdata_i[1:0];
      an_q <= s_axis_tdata_i[2 +: W];
      ad_q <= s_axis_tdata_i[66 +: W];
      bn_q <= s_axis_tdata_i[130 +: W];
      bd_q <= s_axis_tdata_i[194 +: W];
    end
    acc_q <= mul_p64;
    if (state_q == ST_MUL && ph_q == 2'd2 && mc_q <= 3'd4) begin
      case (mc_q)
        3'd0: p_q[0] <= mul_p;
        3'd1: p_q[1] <= mul_p;
        3'd2: p_q[2] <= mul_p;
        3'd3: p_q[3] <= mul_p;
        default: g_q <= mul_p;
      endcase
    end else begin
      g_q <= g_d;
    end
    n_q <= n_d; d_q <= d_d; x_q <= x_d; y_q <= y_d;
    zf_q <= zf_d; ng_q <= ng_d; dg_q <= dg_d; fl_q <= fl_d;
    lt_q <= lt_d; eq_q <= eq_d; gt_q <= gt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; mc_q <= '0; ph_q <= '0; sc_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; mc_q <= mc_d; ph_q <= ph_d; sc_q <= sc_d;
      ov_q <= (state_q == ST_FLUSH);
    end
  end

  assign mn   = magf(n_q);
  assign md   = magf(d_q);
  assign wmax = {1'b0, {(W-1){1'b1}}};
  assign nn   = ng_q ? (~div_q + 1'b1) : div_q;
  assign dd   = dg_q ? (~div_q + 1'b1) : div_q;

  always_comb begin
    state_d = state_q; mc_d = mc_q; ph_d = ph_q; sc_d = sc_q;
    n_d = n_q; d_d = d_q; x_d = x_q; y_d = y_q; g_d = g_q;
    zf_d = zf_q; ng_d = ng_q; dg_d = dg_q; fl_d = fl_q;
    lt_d = lt_q; eq_d = eq_q; gt_d = gt_q;
    div_start = 1'b0; div_n = x_q; div_d = y_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid_i) begin
        mc_d = '0; ph_d = '0; state_d = ST_MUL;
      end
      ST_MUL: begin
        if (ph_q == 2'd2) begin
          ph_d = '0;
          mc_d = mc_q + 1'b1;
          if (mc_q == 3'd4) state_d = ST_RAW;
        end else begin
          ph_d = ph_q + 1'b1;
        end
      end
      ST_RAW: begin
        // g_q holds ad*bn here
        case (op_q)
          OP_ADD:  begin n_d = p_q[0] + p_q[1]; d_d = p_q[3]; end
          OP_SUB:  begin n_d = p_q[0] - p_q[1]; d_d = p_q[3]; end
          OP_MUL:  begin n_d = p_q[2]; d_d = p_q[3]; end
          default: begin n_d = p_q[0]; d_d = g_q; end
        endcase
        zf_d = (d_d == '0);
        if (zf_d) begin
          n_d = ((an_q != '0) && (posf(an_q) != posf(ad_q))) ? ~wmax : wmax;
          d_d = {{(W-1){1'b0}}, 1'b1};
        end
        eq_d = (p_q[0] == p_q[1]);
        fl_d = posf(bd_q) != posf(ad_q);
        lt_d = fl_d ? ($signed(p_q[1]) < $signed(p_q[0]))
                    : ($signed(p_q[0]) < $signed(p_q[1]));
        gt_d = fl_d ? ($signed(p_q[0]) < $signed(p_q[1]))
                    : ($signed(p_q[1]) < $signed(p_q[0]));
        state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        ng_d = n_q[W-1]; dg_d = d_q[W-1];
        if (mn == '0) begin
          n_d = '0; d_d = {{(W-1){1'b0}}, 1'b1}; state_d = ST_DONE;
        end else if (!ov_q) begin
          div_start = 1'b1; div_n = md; div_d = mn;
          x_d = (mn > md) ? md : mn;  // smaller
          y_d = (mn > md) ? mn : md;
        end else if (div_done) begin
          if ({{(W > 32 ? 0 : 32 - W){1'b0}}, div_q} >= flush_q) begin
            n_d = '0; d_d = {{(W-1){1'b0}}, 1'b1}; state_d = ST_DONE;
          end else begin
            div_start = 1'b1; div_n = y_q; div_d = x_q; state_d = ST_GCD;
          end
        end
      end
      ST_GCD: if (div_done) begin
        if (div_r == '0) begin
          g_d = x_q; div_start = 1'b1; div_n = mn; div_d = x_q;
          state_d = ST_QN;
        end else begin
          y_d = x_q; x_d = div_r; div_start = 1'b1; div_n = x_q; div_d = div_r;
        end
      end
      ST_QN: if (div_done) begin
        n_d = nn; div_start = 1'b1; div_n = md; div_d = g_q; state_d = ST_QD;
      end
      ST_QD: if (div_done) begin
        d_d = dd; sc_d = '0; state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (sc_q == SW'(W) || !({{(W > 32 ? 0 : 32 - W){1'b0}}, mn} > reduce_q
            && {{(W > 32 ? 0 : 32 - W){1'b0}}, md} > reduce_q)) begin
          state_d = ST_DONE;
        end else begin
          n_d = {n_q[W-1], n_q[W-1:1]}; d_d = {d_q[W-1], d_q[W-1:1]};
          sc_d = sc_q + 1'b1;
        end
      end
      ST_DONE: if (m_axis_tready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_DONE);
  assign m_axis_tdata_o  = {4'd0, zf_q, gt_q, eq_q, lt_q,
                            {{(64-W){d_q[W-1]}}, d_q}, {{(64-W){n_q[W-1]}}, n_q}};

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(lt_q && gt_q) && !(eq_q && (lt_q || gt_q)))
    else $error("compare flags conflict");
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> d_q != '0) else $error("zero result denominator");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o) else $error("accept while result pending");

endmodule
